// ----- src/hfifo_pkg.sv -----
// Shared types, codes and defaults for the handle FIFO with refill hysteresis.
package hfifo_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 32;
  localparam int unsigned HANDLE_BITS_DEF = 16;

  localparam int unsigned REG_W    = 6;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_COUNT    = 2'd0,
    REG_BELOW_LEVEL  = 2'd1,
    REG_ABOVE_LEVEL  = 2'd2,
    REG_REFILL_LEVEL = 2'd3
  } cfg_idx_e;

  localparam logic [REG_W-1:0] MAX_COUNT_RST    = 6'd32;
  localparam logic [REG_W-1:0] BELOW_LEVEL_RST  = 6'd0;
  localparam logic [REG_W-1:0] ABOVE_LEVEL_RST  = 6'd32;
  localparam logic [REG_W-1:0] REFILL_LEVEL_RST = 6'd0;

  typedef struct packed {
    action_e             action;
    logic [HANDLE_W-1:0] handle_in;
  } item_t;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] handle_out;
    logic [REG_W-1:0]    fill_level;
    logic                notify;
    logic [REG_W-1:0]    notify_level;
    logic [REG_W-1:0]    peak_fill;
    logic [CNT_W-1:0]    full_events;
    logic [CNT_W-1:0]    empty_events;
    logic [CNT_W-1:0]    enqueue_total;
    logic [CNT_W-1:0]    dequeue_total;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;  // latch the item and launch the slot read
    logic execute;  // apply the transaction and register the result
  } dp_cmd_t;

endpackage

// ----- src/hfifo_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hfifo_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/hfifo_ctrl.sv -----
// Transaction sequencer: accept, then execute, then strobe the result.
module hfifo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              result_strobe_o,
  output hfifo_pkg::dp_cmd_t cmd_o
);
  import hfifo_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   strobe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      busy_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          strobe_q <= 1'b0;
          if (start) begin
            state_q <= S_EXEC;
            busy_q  <= 1'b1;
          end
        end
        S_EXEC: begin
          state_q  <= S_IDLE;
          busy_q   <= 1'b0;
          strobe_q <= 1'b1;
        end
        default: begin
          state_q  <= S_IDLE;
          busy_q   <= 1'b0;
          strobe_q <= 1'b0;
        end
      endcase
    end
  end

  assign cmd_o.capture   = (state_q == S_IDLE) && start;
  assign cmd_o.execute   = (state_q == S_EXEC);
  assign busy            = busy_q;
  assign result_strobe_o = strobe_q;

endmodule

// ----- src/hfifo_dp.sv -----
// Datapath: config registers, pointers, fill, refill hold, counters, slot RAM.
module hfifo_dp #(
  parameter int unsigned QueueDepth = hfifo_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned HandleBits = hfifo_pkg::HANDLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hfifo_pkg::dp_cmd_t                  cmd_i,
  input  hfifo_pkg::item_t                    item_i,
  input  logic                                cfg_valid_i,
  input  logic [hfifo_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [hfifo_pkg::REG_W-1:0]         cfg_data_i,
  output hfifo_pkg::result_t                  result_o
);
  import hfifo_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned FillW = $clog2(QueueDepth + 1);
  localparam int unsigned CmpW = (FillW > REG_W) ? FillW : REG_W;
  localparam logic [PtrW-1:0] LastSlot = PtrW'(QueueDepth - 1);
  localparam logic [FillW-1:0] FullFill = FillW'(QueueDepth);

  // Configuration registers
  logic [REG_W-1:0] max_count_q, below_level_q, above_level_q, refill_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q    <= MAX_COUNT_RST;
      below_level_q  <= BELOW_LEVEL_RST;
      above_level_q  <= ABOVE_LEVEL_RST;
      refill_level_q <= REFILL_LEVEL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_MAX_COUNT:    max_count_q    <= cfg_data_i;
        REG_BELOW_LEVEL:  below_level_q  <= cfg_data_i;
        REG_ABOVE_LEVEL:  above_level_q  <= cfg_data_i;
        REG_REFILL_LEVEL: refill_level_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Queue state
  logic [PtrW-1:0]  rp_q, rp_d, wp_q, wp_d;
  logic [FillW-1:0] fill_q, fill_d, peak_q, peak_d;
  logic             hold_q, hold_d;
  logic [CNT_W-1:0] full_cnt_q, full_cnt_d, empty_cnt_q, empty_cnt_d;
  logic [CNT_W-1:0] enq_cnt_q, enq_cnt_d, deq_cnt_q, deq_cnt_d;

  item_t   item_q;
  result_t result_q, result_d;

  logic [HandleBits-1:0] rdata;
  logic                  ram_we;

  hfifo_ram #(
    .Width(HandleBits),
    .Depth(QueueDepth)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(HandleBits'(item_q.handle_in)),
    .re_i   (cmd_i.capture),
    .raddr_i(rp_q),
    .rdata_o(rdata)
  );

  // Widened views for compares
  logic [CmpW-1:0] fill_c, max_c, below_c, above_c, refill_c, after_c;
  logic            reject, hold_eff;
  logic [FillW-1:0] after, nlevel;
  logic             notify;
  status_e          status;
  logic [HandleBits-1:0] hout;

  assign fill_c   = CmpW'(fill_q);
  assign max_c    = CmpW'(max_count_q);
  assign below_c  = CmpW'(below_level_q);
  assign above_c  = CmpW'(above_level_q);
  assign refill_c = CmpW'(refill_level_q);
  assign after_c  = CmpW'(after);

  assign reject   = (fill_c == max_c) || (fill_q >= FullFill);
  // Hold drops at the start of a dequeue once the fill is past the refill level.
  assign hold_eff = hold_q && !(refill_c < fill_c);

  always_comb begin
    rp_d        = rp_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    peak_d      = peak_q;
    hold_d      = hold_q;
    full_cnt_d  = full_cnt_q;
    empty_cnt_d = empty_cnt_q;
    enq_cnt_d   = enq_cnt_q;
    deq_cnt_d   = deq_cnt_q;
    status      = ST_DONE;
    hout        = '0;
    notify      = 1'b0;
    nlevel      = '0;
    after       = '0;
    ram_we      = 1'b0;

    if (item_q.action == ACT_ENQ) begin
      // High-water notice reports the fill before the item, even if rejected.
      if (fill_c > above_c) begin
        notify = 1'b1;
        nlevel = fill_q;
      end
      if (reject) begin
        full_cnt_d = full_cnt_q + 1'b1;
        status     = ST_FULL;
      end else begin
        ram_we    = cmd_i.execute;
        wp_d      = (wp_q == LastSlot) ? '0 : wp_q + 1'b1;
        fill_d    = fill_q + 1'b1;
        enq_cnt_d = enq_cnt_q + 1'b1;
        if (fill_d > peak_q) begin
          peak_d = fill_d;
        end
      end
    end else begin
      hold_d = hold_eff;
      if (!hold_eff && (fill_q != '0)) begin
        hout      = rdata;
        rp_d      = (rp_q == LastSlot) ? '0 : rp_q + 1'b1;
        fill_d    = fill_q - 1'b1;
        after     = fill_d;
        deq_cnt_d = deq_cnt_q + 1'b1;
      end else begin
        empty_cnt_d = empty_cnt_q + 1'b1;
        status      = ST_EMPTY;
        if (!hold_eff && (refill_c > fill_c)) begin
          hold_d = 1'b1;
        end
      end
      if ((after_c < below_c) || (after_c > above_c)) begin
        notify = 1'b1;
        nlevel = after;
      end
    end

    result_d.status        = status;
    result_d.handle_out    = HANDLE_W'(hout);
    result_d.fill_level    = REG_W'(fill_d);
    result_d.notify        = notify;
    result_d.notify_level  = REG_W'(nlevel);
    result_d.peak_fill     = REG_W'(peak_d);
    result_d.full_events   = full_cnt_d;
    result_d.empty_events  = empty_cnt_d;
    result_d.enqueue_total = enq_cnt_d;
    result_d.dequeue_total = deq_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      peak_q      <= '0;
      hold_q      <= 1'b0;
      full_cnt_q  <= '0;
      empty_cnt_q <= '0;
      enq_cnt_q   <= '0;
      deq_cnt_q   <= '0;
    end else if (cmd_i.execute) begin
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      peak_q      <= peak_d;
      hold_q      <= hold_d;
      full_cnt_q  <= full_cnt_d;
      empty_cnt_q <= empty_cnt_d;
      enq_cnt_q   <= enq_cnt_d;
      deq_cnt_q   <= deq_cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.execute) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

// ----- src/handle_fifo_with_refill_hysteresis_top.sv -----
// Top level of the buffer-handle FIFO with watermark notices and refill hold.
//
// Usage:
//  - Command channel: drive item_i and raise start; the transaction is taken
//    at a clock edge where start is high and busy is low. action selects
//    enqueue or dequeue of handle_in.
//  - Result channel: result_strobe_o is high for exactly one cycle with the
//    result on result_o. There is no backpressure; capture it on that cycle.
//  - Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i.
//    cfg_ready_o is always high. Write only while no transaction is in flight.
//  - Timing: accept edge launches the slot RAM read, the next edge applies the
//    transaction and registers the result, so the strobe is high in the cycle
//    after that edge. busy covers the execute cycle only, so a new transaction
//    can be taken while the strobe is showing, but not during the execute cycle.
//  - Reset: pointers, fill, hold and statistics clear; thresholds take their
//    default values. Slot contents are not cleared and need no clearing pass.
module handle_fifo_with_refill_hysteresis_top #(
  parameter int unsigned QueueDepth = hfifo_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned HandleBits = hfifo_pkg::HANDLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  hfifo_pkg::item_t                item_i,
  output logic                            result_strobe_o,
  output hfifo_pkg::result_t              result_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hfifo_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [hfifo_pkg::REG_W-1:0]     cfg_data_i
);
  import hfifo_pkg::*;

  dp_cmd_t cmd;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  hfifo_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_strobe_o(result_strobe_o),
    .cmd_o          (cmd)
  );

  hfifo_dp #(
    .QueueDepth(QueueDepth),
    .HandleBits(HandleBits)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .item_i     (item_i),
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (result_o)
  );

  // Every accepted transaction moves into the execute cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // A result follows exactly one execute cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (result_strobe_o && !busy))
    else $error("execute cycle did not produce a result");

  // Results never come back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |=> !result_strobe_o)
    else $error("result strobe held for more than one cycle");

  // A failed dequeue or rejected enqueue returns no handle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && (result_o.status == ST_EMPTY || result_o.status == ST_FULL))
      |-> (result_o.handle_out == '0))
    else $error("handle returned on a failed transaction");

endmodule
